### sv/ccs_pkg.sv
`default_nettype none

package ccs_pkg;

  localparam logic [3:0] MAX_SPLICES = 4'd15;

  localparam logic [7:0] CH_BS    = 8'h5C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SP    = 8'h20;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_COMMENT  = 2'd1;
  localparam logic [1:0] ERR_LITERAL  = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  localparam logic [1:0] TERM_SLOT = 2'd3;

  typedef enum logic [1:0] {
    MODE_CODE,
    MODE_LINE,
    MODE_BLOCK,
    MODE_LIT
  } mode_t;

  typedef struct packed {
    logic       bs_held;
    logic [3:0] pending;
    logic       slash_held;
    logic [3:0] slash_spl;
    mode_t      mode;
    logic       star;
    logic       dq;
    logic       esc;
    logic       halted;
  } st_t;

  // n restored splices, then optionally one character
  typedef struct packed {
    logic       vld;
    logic [3:0] spl;
    logic       has_ch;
    logic [7:0] ch;
  } seg_t;

  typedef struct packed {
    seg_t [2:0] seg;
    logic       term;
    logic [1:0] err;
  } res_list_t;

  typedef struct packed {
    st_t        s;
    seg_t       a;
    seg_t       b;
    logic [1:0] err;
  } lc_t;

  typedef struct packed {
    st_t       s;
    res_list_t list;
  } step_t;

  function automatic seg_t mk_seg(logic [3:0] n, logic has_ch, logic [7:0] ch);
    seg_t r;
    r.vld    = (n != 4'd0) || has_ch;
    r.spl    = n;
    r.has_ch = has_ch;
    r.ch     = ch;
    return r;
  endfunction

  function automatic lc_t lchar(st_t s, logic [7:0] c, logic [3:0] n);
    lc_t        r;
    logic       go;
    logic [7:0] q;
    r     = '0;
    r.s   = s;
    r.err = ERR_NONE;
    go    = 1'b1;
    q     = s.dq ? CH_DQ : CH_SQ;
    case (s.mode)
      MODE_CODE: begin
        if (s.slash_held) begin
          r.s.slash_held = 1'b0;
          if (c == CH_SLASH) begin
            r.s.mode = MODE_LINE;
            go = 1'b0;
          end else if (c == CH_STAR) begin
            r.s.mode = MODE_BLOCK;
            r.s.star = 1'b0;
            go = 1'b0;
          end else begin
            r.a = mk_seg(s.slash_spl, 1'b1, CH_SLASH);
            r.s.slash_spl = 4'd0;
          end
        end
        if (go) begin
          if (c == CH_SLASH) begin
            r.s.slash_held = 1'b1;
            r.s.slash_spl  = n;
          end else begin
            r.b = mk_seg(n, 1'b1, c);
            if (c == CH_SQ || c == CH_DQ) begin
              r.s.mode = MODE_LIT;
              r.s.dq   = (c == CH_DQ);
              r.s.esc  = 1'b0;
            end
          end
        end
      end
      MODE_LINE: begin
        if (c == CH_NL) begin
          r.b = mk_seg(4'd0, 1'b1, CH_NL);
          r.s.mode = MODE_CODE;
        end
      end
      MODE_BLOCK: begin
        if (s.star && c == CH_SLASH) begin
          r.s.mode = MODE_CODE;
          r.s.star = 1'b0;
          r.b = mk_seg(4'd0, 1'b1, CH_SP);
        end else begin
          r.s.star = (c == CH_STAR);
        end
      end
      default: begin
        if (s.esc) begin
          r.s.esc = 1'b0;
          r.b = mk_seg(n, 1'b1, c);
        end else if (c == CH_BS) begin
          r.s.esc = 1'b1;
          r.b = mk_seg(n, 1'b1, c);
        end else if (c == q) begin
          r.b = mk_seg(n, 1'b1, c);
          r.s.mode = MODE_CODE;
        end else if (c == CH_NL) begin
          r.err = ERR_LITERAL;
        end else begin
          r.b = mk_seg(n, 1'b1, c);
        end
      end
    endcase
    return r;
  endfunction

  function automatic step_t step(st_t s, logic [7:0] c, logic eoi);
    step_t r;
    st_t   t;
    lc_t   l1;
    lc_t   l2;
    logic  go;
    r  = '0;
    t  = s;
    go = 1'b1;
    l1 = '0;
    l2 = '0;
    r.list.err = ERR_NONE;
    if (!s.halted) begin
      if (eoi) begin
        if (t.bs_held) begin
          t.bs_held = 1'b0;
          l1 = lchar(t, CH_BS, t.pending);
          t = l1.s;
          r.list.seg[0] = l1.a;
          r.list.seg[1] = l1.b;
          r.list.err = l1.err;
          t.pending = 4'd0;
        end
        if (r.list.err == ERR_NONE) begin
          case (t.mode)
            MODE_CODE: begin
              if (t.slash_held) begin
                t.slash_held = 1'b0;
                r.list.seg[1] = mk_seg(t.slash_spl, 1'b1, CH_SLASH);
                t.slash_spl = 4'd0;
              end
              r.list.seg[2] = mk_seg(t.pending, 1'b0, 8'd0);
            end
            MODE_LINE:  r.list.seg[2] = mk_seg(t.pending, 1'b0, 8'd0);
            MODE_BLOCK: r.list.err = ERR_COMMENT;
            default:    r.list.err = ERR_LITERAL;
          endcase
        end
        t.pending = 4'd0;
        r.list.term = 1'b1;
        t.halted = 1'b1;
      end else begin
        if (t.bs_held) begin
          t.bs_held = 1'b0;
          if (c == CH_NL) begin
            if (t.pending >= MAX_SPLICES) begin
              r.list.err = ERR_OVERFLOW;
            end else begin
              t.pending = t.pending + 4'd1;
            end
            go = 1'b0;
          end else begin
            l1 = lchar(t, CH_BS, t.pending);
            t = l1.s;
            r.list.seg[0] = l1.a;
            r.list.seg[1] = l1.b;
            r.list.err = l1.err;
            t.pending = 4'd0;
          end
        end
        if (r.list.err == ERR_NONE && go) begin
          if (c == CH_BS) begin
            t.bs_held = 1'b1;
          end else begin
            l2 = lchar(t, c, t.pending);
            t = l2.s;
            t.pending = 4'd0;
            if (l2.a.vld) begin
              r.list.seg[1] = l2.a;
            end
            r.list.seg[2] = l2.b;
            r.list.err = l2.err;
          end
        end
        if (r.list.err != ERR_NONE) begin
          r.list.term = 1'b1;
          t.halted = 1'b1;
        end
      end
    end
    r.s = t;
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/ccs_in_if.sv
`default_nettype none

interface ccs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_input;

  modport source (output valid, output in_char, output end_of_input, input ready);
  modport sink (input valid, input in_char, input end_of_input, output ready);
endinterface

`default_nettype wire

### sv/ccs_out_if.sv
`default_nettype none

interface ccs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       stream_done;
  logic [1:0] error_code;

  modport source (output valid, output out_char, output last, output stream_done,
                  output error_code, input ready);
  modport sink (input valid, input out_char, input last, input stream_done,
                input error_code, output ready);
endinterface

`default_nettype wire

### sv/ccs_emitter.sv
`default_nettype none

module ccs_emitter (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire ccs_pkg::res_list_t list_in,
  output logic                   free,
  ccs_out_if.source              stripped
);

  typedef struct packed {
    logic       found;
    logic [1:0] idx;
  } slot_t;

  function automatic slot_t find_slot(ccs_pkg::res_list_t l, logic [2:0] from);
    slot_t      r;
    logic [3:0] full;
    r    = '0;
    full = {l.term, l.seg[2].vld, l.seg[1].vld, l.seg[0].vld};
    for (int j = 0; j < 4; j++) begin
      if (!r.found && full[j] && (3'(j) >= from)) begin
        r.found = 1'b1;
        r.idx   = 2'(j);
      end
    end
    return r;
  endfunction

  logic               busy;
  ccs_pkg::res_list_t list;
  logic [1:0]         idx;
  logic [3:0]         cnt;
  logic               ph;

  ccs_pkg::seg_t cur;
  slot_t         first;
  slot_t         nxt;
  logic          is_term;
  logic          in_spl;
  logic          seg_end;
  logic          last_res;
  logic          fire;

  always_comb begin
    first    = find_slot(list_in, 3'd0);
    nxt      = find_slot(list, {1'b0, idx} + 3'd1);
    is_term  = (idx == ccs_pkg::TERM_SLOT);
    cur      = is_term ? '0 : list.seg[idx];
    in_spl   = !is_term && (cnt != cur.spl);
    seg_end  = is_term || !in_spl ||
               (ph && (({1'b0, cnt} + 5'd1) == {1'b0, cur.spl}) && !cur.has_ch);
    last_res = seg_end && !nxt.found;
    fire     = busy && stripped.ready;
    free     = !busy || (stripped.ready && last_res);
  end

  always_comb begin
    stripped.valid       = busy;
    stripped.last        = last_res;
    stripped.stream_done = is_term;
    stripped.error_code  = is_term ? list.err : ccs_pkg::ERR_NONE;
    if (is_term) begin
      stripped.out_char = 8'd0;
    end else if (in_spl) begin
      stripped.out_char = ph ? ccs_pkg::CH_NL : ccs_pkg::CH_BS;
    end else begin
      stripped.out_char = cur.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
      cnt  <= 4'd0;
      ph   <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= first.idx;
      cnt  <= 4'd0;
      ph   <= 1'b0;
    end else if (fire) begin
      if (seg_end) begin
        if (last_res) begin
          busy <= 1'b0;
        end else begin
          idx <= nxt.idx;
          cnt <= 4'd0;
          ph  <= 1'b0;
        end
      end else if (ph) begin
        ph  <= 1'b0;
        cnt <= cnt + 4'd1;
      end else begin
        ph <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      list <= list_in;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (rst) load |-> free)
    else $error("list loaded while emitter still busy");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    stripped.valid && stripped.stream_done |-> stripped.last)
    else $error("end marker is not the last result");
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    busy && !last_res |=> busy)
    else $error("emitter dropped results");
`endif

endmodule

`default_nettype wire

### sv/c_comment_stripper.sv
`default_nettype none

// Streaming C comment stripper. Each request on raw carries one source byte
// (or an end-of-input flag) and yields zero or more requests on stripped,
// the final one flagged by last. A byte is taken every cycle while it yields
// at most one result and stripped is ready; one yielding k results (restored
// splices, a held slash, up to 63 in all) holds raw off while the output
// sequencer, emitting one result per cycle while stripped is ready, sends the
// rest. The next byte is taken in the cycle the final result is taken. After
// the end marker or an error result, bytes are taken and dropped until reset.
module c_comment_stripper (
  input  wire logic clk,
  input  wire logic rst,
  ccs_in_if.sink    raw,
  ccs_out_if.source stripped
);

  ccs_pkg::st_t   st;
  ccs_pkg::step_t nx;
  logic           accept;
  logic           any_res;
  logic           load;
  logic           free;

  always_comb begin
    nx      = ccs_pkg::step(st, raw.in_char, raw.end_of_input);
    any_res = nx.list.term | nx.list.seg[0].vld | nx.list.seg[1].vld | nx.list.seg[2].vld;
    accept  = raw.valid && raw.ready;
    load    = accept && any_res;
  end

  assign raw.ready = free;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= nx.s;
    end
  end

  ccs_emitter u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .list_in  (nx.list),
    .free     (free),
    .stripped (stripped)
  );

`ifndef NO_ASSERTIONS
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst) st.halted |=> st.halted)
    else $error("halted state cleared without reset");
  a_halt_silent: assert property (@(posedge clk) disable iff (rst) st.halted |-> !load)
    else $error("results produced after stream ended");
  a_slash_code: assert property (@(posedge clk) disable iff (rst)
    st.slash_held |-> st.mode == ccs_pkg::MODE_CODE)
    else $error("slash held outside code");
`endif

endmodule

`default_nettype wire

### sim/tb_c_comment_stripper.sv
`default_nettype none

module tb_c_comment_stripper;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM     = 430;
  localparam int MAX_RESULTS  = 63;
  localparam int LIMIT_CYCLES = 1000000;

  typedef struct packed {
    logic            bs_wait;
    logic [3:0]      splices;
    logic            slash_wait;
    logic [3:0]      slash_spl;
    ccs_pkg::mode_t  mode;
    logic            star;
    logic            dquote;
    logic            esc;
    logic            stopped;
    logic [1:0]      fault;
  } strip_st_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       done;
    logic [1:0] err;
  } strip_res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fixed;
  } dir_row_t;

  logic clk;
  logic rst;
  logic req_fixed;

  ccs_in_if  raw_bus ();
  ccs_out_if stripped_bus ();

  c_comment_stripper dut (
    .clk      (clk),
    .rst      (rst),
    .raw      (raw_bus),
    .stripped (stripped_bus)
  );

  strip_res_t pred_buf[$];
  strip_res_t expect_q[$];
  logic [7:0] text_q[$];
  strip_st_t  model_st = '0;
  strip_st_t  gen_st = '0;
  int         mismatches = 0;
  int         cycles = 0;
  int         burst_left = 0;

  // fixed rows expect the byte itself back as a single request
  dir_row_t directed_rows [25] = '{
    '{8'h00, 1'b1}, '{8'hFF, 1'b1}, '{8'h61, 1'b1},
    '{ccs_pkg::CH_SLASH, 1'b0}, '{ccs_pkg::CH_SLASH, 1'b0}, '{ccs_pkg::CH_BS, 1'b0},
    '{ccs_pkg::CH_NL, 1'b0}, '{ccs_pkg::CH_NL, 1'b0},
    '{ccs_pkg::CH_SLASH, 1'b0}, '{ccs_pkg::CH_STAR, 1'b0}, '{ccs_pkg::CH_SLASH, 1'b0},
    '{ccs_pkg::CH_STAR, 1'b0},
    '{ccs_pkg::CH_SLASH, 1'b0},
    '{ccs_pkg::CH_BS, 1'b0}, '{ccs_pkg::CH_NL, 1'b0}, '{ccs_pkg::CH_DQ, 1'b0},
    '{ccs_pkg::CH_BS, 1'b0}, '{ccs_pkg::CH_DQ, 1'b0},
    '{ccs_pkg::CH_SQ, 1'b0}, '{ccs_pkg::CH_DQ, 1'b0},
    '{ccs_pkg::CH_SLASH, 1'b0}, '{8'h62, 1'b0}, '{ccs_pkg::CH_SQ, 1'b0},
    '{ccs_pkg::CH_SQ, 1'b0},
    '{8'h80, 1'b1}
  };

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void put_res(input logic [7:0] ch, input logic done,
                                  input logic [1:0] err);
    strip_res_t r;
    r.ch   = ch;
    r.last = 1'b0;
    r.done = done;
    r.err  = err;
    if (pred_buf.size() < MAX_RESULTS) pred_buf.push_back(r);
  endfunction

  function automatic void put_splice_run(input logic [3:0] n);
    for (int k = 0; k < n; k++) begin
      put_res(ccs_pkg::CH_BS, 1'b0, ccs_pkg::ERR_NONE);
      put_res(ccs_pkg::CH_NL, 1'b0, ccs_pkg::ERR_NONE);
    end
  endfunction

  function automatic void put_char(input logic [7:0] ch, input logic [3:0] n);
    put_splice_run(n);
    put_res(ch, 1'b0, ccs_pkg::ERR_NONE);
  endfunction

  function automatic strip_st_t take_logical(input strip_st_t s, input logic [7:0] c,
                                             input logic [3:0] n);
    logic [7:0] closer;
    closer = s.dquote ? ccs_pkg::CH_DQ : ccs_pkg::CH_SQ;
    case (s.mode)
      ccs_pkg::MODE_CODE: begin
        if (s.slash_wait) begin
          s.slash_wait = 1'b0;
          if (c == ccs_pkg::CH_SLASH) begin
            s.mode = ccs_pkg::MODE_LINE;
            return s;
          end
          if (c == ccs_pkg::CH_STAR) begin
            s.mode = ccs_pkg::MODE_BLOCK;
            s.star = 1'b0;
            return s;
          end
          put_char(ccs_pkg::CH_SLASH, s.slash_spl);
          s.slash_spl = 4'd0;
        end
        if (c == ccs_pkg::CH_SLASH) begin
          s.slash_wait = 1'b1;
          s.slash_spl  = n;
        end else begin
          put_char(c, n);
          if (c == ccs_pkg::CH_SQ || c == ccs_pkg::CH_DQ) begin
            s.mode   = ccs_pkg::MODE_LIT;
            s.dquote = (c == ccs_pkg::CH_DQ);
            s.esc    = 1'b0;
          end
        end
      end
      ccs_pkg::MODE_LINE: begin
        if (c == ccs_pkg::CH_NL) begin
          put_res(ccs_pkg::CH_NL, 1'b0, ccs_pkg::ERR_NONE);
          s.mode = ccs_pkg::MODE_CODE;
        end
      end
      ccs_pkg::MODE_BLOCK: begin
        if (s.star && c == ccs_pkg::CH_SLASH) begin
          s.mode = ccs_pkg::MODE_CODE;
          s.star = 1'b0;
          put_res(ccs_pkg::CH_SP, 1'b0, ccs_pkg::ERR_NONE);
        end else begin
          s.star = (c == ccs_pkg::CH_STAR);
        end
      end
      default: begin
        if (s.esc) begin
          s.esc = 1'b0;
          put_char(c, n);
        end else if (c == ccs_pkg::CH_BS) begin
          s.esc = 1'b1;
          put_char(c, n);
        end else if (c == closer) begin
          put_char(c, n);
          s.mode = ccs_pkg::MODE_CODE;
        end else if (c == ccs_pkg::CH_NL) begin
          s.fault = ccs_pkg::ERR_LITERAL;
        end else begin
          put_char(c, n);
        end
      end
    endcase
    return s;
  endfunction

  // results of one request go to pred_buf, last flags not yet set
  function automatic strip_st_t strip_next(input strip_st_t s, input logic [7:0] c,
                                           input logic eoi);
    logic consumed;
    consumed = 1'b0;
    s.fault  = ccs_pkg::ERR_NONE;
    if (s.stopped) return s;
    if (eoi) begin
      if (s.bs_wait) begin
        s.bs_wait = 1'b0;
        s = take_logical(s, ccs_pkg::CH_BS, s.splices);
        s.splices = 4'd0;
      end
      if (s.fault == ccs_pkg::ERR_NONE) begin
        case (s.mode)
          ccs_pkg::MODE_CODE: begin
            if (s.slash_wait) begin
              s.slash_wait = 1'b0;
              put_char(ccs_pkg::CH_SLASH, s.slash_spl);
              s.slash_spl = 4'd0;
            end
            put_splice_run(s.splices);
          end
          ccs_pkg::MODE_LINE:  put_splice_run(s.splices);
          ccs_pkg::MODE_BLOCK: s.fault = ccs_pkg::ERR_COMMENT;
          default:             s.fault = ccs_pkg::ERR_LITERAL;
        endcase
      end
      s.splices = 4'd0;
      put_res(8'h00, 1'b1, s.fault);
      s.stopped = 1'b1;
    end else begin
      if (s.bs_wait) begin
        s.bs_wait = 1'b0;
        if (c == ccs_pkg::CH_NL) begin
          if (s.splices >= ccs_pkg::MAX_SPLICES) s.fault = ccs_pkg::ERR_OVERFLOW;
          else s.splices = s.splices + 4'd1;
          consumed = 1'b1;
        end else begin
          s = take_logical(s, ccs_pkg::CH_BS, s.splices);
          s.splices = 4'd0;
        end
      end
      if (s.fault == ccs_pkg::ERR_NONE && !consumed) begin
        if (c == ccs_pkg::CH_BS) begin
          s.bs_wait = 1'b1;
        end else begin
          s = take_logical(s, c, s.splices);
          s.splices = 4'd0;
        end
      end
      if (s.fault != ccs_pkg::ERR_NONE) begin
        put_res(8'h00, 1'b1, s.fault);
        s.stopped = 1'b1;
      end
    end
    return s;
  endfunction

  function automatic logic [7:0] any_char();
    case ($urandom_range(0, 11))
      0, 1:    return 8'($urandom_range(0, 255));
      2:       return ccs_pkg::CH_STAR;
      3:       return ccs_pkg::CH_SLASH;
      4:       return ccs_pkg::CH_SP;
      5:       return ccs_pkg::CH_NL;
      6:       return ccs_pkg::CH_BS;
      7:       return ccs_pkg::CH_SQ;
      8:       return ccs_pkg::CH_DQ;
      default: return 8'(8'h61 + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic void push_splices(input int n);
    repeat (n) begin
      text_q.push_back(ccs_pkg::CH_BS);
      text_q.push_back(ccs_pkg::CH_NL);
    end
  endfunction

  function automatic void push_text(input logic [7:0] c);
    if ($urandom_range(0, 7) == 0) push_splices($urandom_range(1, 3));
    text_q.push_back(c);
  endfunction

  // C-like fragments: code, comments, literals, splice runs, raw noise
  function automatic void fill_fragment();
    logic [7:0] q;
    case ($urandom_range(0, 9))
      0, 1, 2: repeat ($urandom_range(1, 8)) push_text(any_char());
      3: begin
        push_text(ccs_pkg::CH_SLASH);
        push_text(ccs_pkg::CH_SLASH);
        repeat ($urandom_range(0, 10)) push_text(any_char());
        push_text(ccs_pkg::CH_NL);
      end
      4, 5: begin
        push_text(ccs_pkg::CH_SLASH);
        push_text(ccs_pkg::CH_STAR);
        repeat ($urandom_range(0, 12))
          push_text(($urandom_range(0, 2) == 0) ? ccs_pkg::CH_STAR : any_char());
        push_text(ccs_pkg::CH_STAR);
        push_text(ccs_pkg::CH_SLASH);
      end
      6, 7: begin
        q = $urandom_range(0, 1) ? ccs_pkg::CH_DQ : ccs_pkg::CH_SQ;
        push_text(q);
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 4) == 0) push_text(ccs_pkg::CH_BS);
          push_text(any_char());
        end
        push_text(q);
      end
      8: begin
        push_splices($urandom_range(1, ccs_pkg::MAX_SPLICES));
        push_text(any_char());
      end
      default: repeat ($urandom_range(1, 4)) push_text(8'($urandom_range(0, 255)));
    endcase
  endfunction

  // tail of the stream; end of input always follows
  function automatic void fill_ending(input int kind);
    case (kind)
      0: push_splices(2);
      1: begin
        text_q.push_back(ccs_pkg::CH_SLASH);
        text_q.push_back(ccs_pkg::CH_STAR);
        text_q.push_back(8'h61);
      end
      2: begin
        text_q.push_back(ccs_pkg::CH_DQ);
        text_q.push_back(8'h61);
        text_q.push_back(ccs_pkg::CH_NL);
      end
      3: push_splices(16);
      4: text_q.push_back(ccs_pkg::CH_SLASH);
      5: text_q.push_back(ccs_pkg::CH_BS);
      default: ;
    endcase
  endfunction

  task automatic send_request(input logic [7:0] c, input logic eoi, input logic fixed);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
      if (gap != 0) begin
        raw_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    gen_st = strip_next(gen_st, c, eoi);
    pred_buf.delete();
    raw_bus.valid        <= 1'b1;
    raw_bus.in_char      <= c;
    raw_bus.end_of_input <= eoi;
    req_fixed            <= fixed;
    @(posedge clk);
    while (!raw_bus.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic wait_drain();
    raw_bus.valid <= 1'b0;
    do @(posedge clk); while (expect_q.size() != 0);
  endtask

  initial begin
    int mode;
    int left;
    int phase;
    stripped_bus.ready = 1'b0;
    mode  = 0;
    left  = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 200);
      end
      left--;
      phase++;
      case (mode)
        0:       stripped_bus.ready <= 1'b1;
        1:       stripped_bus.ready <= 1'($urandom_range(0, 1));
        2:       stripped_bus.ready <= ($urandom_range(0, 3) == 0);
        default: stripped_bus.ready <= ((phase % 7) < 4);
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    strip_res_t want;
    strip_res_t got;
    if (!rst) begin
      if (raw_bus.valid && raw_bus.ready) begin
        pred_buf.delete();
        model_st = strip_next(model_st, raw_bus.in_char, raw_bus.end_of_input);
        if (req_fixed) begin
          want.ch   = raw_bus.in_char;
          want.last = 1'b1;
          want.done = 1'b0;
          want.err  = ccs_pkg::ERR_NONE;
          expect_q.push_back(want);
        end else begin
          foreach (pred_buf[k]) begin
            want      = pred_buf[k];
            want.last = (k == pred_buf.size() - 1);
            expect_q.push_back(want);
          end
        end
        pred_buf.delete();
      end
      if (stripped_bus.valid && stripped_bus.ready) begin
        got.ch   = stripped_bus.out_char;
        got.last = stripped_bus.last;
        got.done = stripped_bus.stream_done;
        got.err  = stripped_bus.error_code;
        if (expect_q.size() == 0) begin
          $display("%0t: unexpected request char %02h last %b done %b err %0d",
                   $realtime, got.ch, got.last, got.done, got.err);
          mismatches++;
        end else begin
          want = expect_q.pop_front();
          if (got.ch !== want.ch || got.last !== want.last || got.done !== want.done ||
              got.err !== want.err) begin
            $display({"%0t: expected char %02h last %b done %b err %0d,",
                      " got char %02h last %b done %b err %0d"},
                     $realtime, want.ch, want.last, want.done, want.err,
                     got.ch, got.last, got.done, got.err);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int sent;
    logic [7:0] c;
    strip_st_t trial;
    rst                  = 1'b1;
    req_fixed            = 1'b0;
    raw_bus.valid        = 1'b0;
    raw_bus.in_char      = 8'h00;
    raw_bus.end_of_input = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].ch, 1'b0, directed_rows[i].fixed);
    wait_drain();

    // keep the stream alive: a byte that would fault is swapped for a plain one
    sent = 0;
    while (sent < N_RANDOM) begin
      if (text_q.size() == 0) fill_fragment();
      c = text_q.pop_front();
      trial = strip_next(gen_st, c, 1'b0);
      pred_buf.delete();
      if (trial.fault != ccs_pkg::ERR_NONE) c = 8'h78;
      send_request(c, 1'b0, 1'b0);
      sent++;
      if ($urandom_range(0, 99) == 0) wait_drain();
    end

    text_q.delete();
    fill_ending($urandom_range(0, 6));
    while (text_q.size() != 0) send_request(text_q.pop_front(), 1'b0, 1'b0);
    send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    repeat (5) send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
    wait_drain();
    repeat (50) @(posedge clk);

    if (mismatches == 0 && expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### c_comment_stripper.f
sv/ccs_pkg.sv
sv/ccs_in_if.sv
sv/ccs_out_if.sv
sv/ccs_emitter.sv
sv/c_comment_stripper.sv
sim/tb_c_comment_stripper.sv
